/* hdl/ppmc_pkg.sv */
// Shared types, constants and helper functions of the parking proximity mode controller.
package ppmc_pkg;

    // Field widths
    localparam int DIST_W    = 12;
    localparam int HYST_W    = 10;
    localparam int ELAPSED_W = 10;
    localparam int PERIOD_W  = 16;
    localparam int SEC_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Saturating millisecond timers
    localparam int TIMER_BITS = 26;
    // A 16-bit second count times 1000 fits in 26 bits.
    localparam int LIMIT_W    = 26;
    localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

    // Signed width for threshold arithmetic: DIST + DIST + HYST plus sign.
    localparam int THR_W = DIST_W + 3;

    localparam int MS_PER_SEC    = 1000;
    // 24 inches expressed in tenth inches.
    localparam int MARGIN_TENTHS = 240;

    // Configuration reset values
    localparam logic [DIST_W-1:0]   RST_TARGET       = DIST_W'(450);
    localparam logic [DIST_W-1:0]   RST_APPROACH     = DIST_W'(480);
    localparam logic [DIST_W-1:0]   RST_LANDING      = DIST_W'(50);
    localparam logic [HYST_W-1:0]   RST_HYST         = HYST_W'(15);
    localparam logic [LIMIT_W-1:0]  RST_STABLE_LIMIT = LIMIT_W'(600 * MS_PER_SEC);
    localparam logic [LIMIT_W-1:0]  RST_VACANT_LIMIT = LIMIT_W'(60 * MS_PER_SEC);
    localparam logic [PERIOD_W-1:0] RST_FAST         = PERIOD_W'(200);
    localparam logic [PERIOD_W-1:0] RST_SLOW         = PERIOD_W'(1500);

    // Operating modes
    typedef enum logic [2:0] {
        MODE_NIGHT  = 3'd0,
        MODE_VACANT = 3'd1,
        MODE_HOMING = 3'd2,
        MODE_HOME   = 3'd3,
        MODE_CLOSE  = 3'd4,
        MODE_PARKED = 3'd5
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET   = 3'd0,
        CFG_APPROACH = 3'd1,
        CFG_LANDING  = 3'd2,
        CFG_HYST     = 3'd3,
        CFG_STABLE   = 3'd4,
        CFG_VACANCY  = 3'd5,
        CFG_FAST     = 3'd6,
        CFG_SLOW     = 3'd7
    } t_cfg_idx;

    // Input beat
    typedef struct packed {
        logic [DIST_W-1:0]    distance_avg;
        logic [DIST_W-1:0]    distance_latest;
        logic                 daytime;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [2:0]          mode;
        logic                mode_changed;
        logic [PERIOD_W-1:0] sample_period_ms;
    } t_out_item;

    // Configuration as seen by the mode logic; timeouts are kept in milliseconds.
    typedef struct packed {
        logic [DIST_W-1:0]   target;
        logic [DIST_W-1:0]   approach_depth;
        logic [DIST_W-1:0]   landing_depth;
        logic [HYST_W-1:0]   hysteresis;
        logic [LIMIT_W-1:0]  stable_limit_ms;
        logic [LIMIT_W-1:0]  vacancy_limit_ms;
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] slow_period;
    } t_cfg;

    // Controller state carried from one beat to the next
    typedef struct packed {
        t_mode                 mode;
        logic [TIMER_BITS-1:0] stable_ms;
        logic [TIMER_BITS-1:0] vacancy_ms;
        logic [PERIOD_W-1:0]   period;
    } t_state;

    // Add elapsed time to a timer, stopping at all ones.
    function automatic logic [TIMER_BITS-1:0] timer_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [ELAPSED_W-1:0]  inc
    );
        logic [TIMER_BITS:0] sum;
        sum = {1'b0, t} + (TIMER_BITS + 1)'(inc);
        if (sum[TIMER_BITS]) begin
            return {TIMER_BITS{1'b1}};
        end
        return sum[TIMER_BITS-1:0];
    endfunction

    // True when a timer has run past its limit.
    function automatic logic timer_expired(
        input logic [TIMER_BITS-1:0] t,
        input logic [LIMIT_W-1:0]    limit
    );
        return CMP_W'(t) > CMP_W'(limit);
    endfunction

endpackage

/* hdl/ppmc_cfg.sv */
// Configuration register file with second-to-millisecond conversion of the timeouts.
module ppmc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [ppmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppmc_pkg::CFG_W-1:0]       i_cfg_data,
    output ppmc_pkg::t_cfg                   o_cfg
);
    import ppmc_pkg::*;

    t_cfg              r_cfg;
    logic [LIMIT_W-1:0] w_limit_ms;

    // Timeouts are written in seconds and held in milliseconds.
    assign w_limit_ms = LIMIT_W'(i_cfg_data[SEC_W-1:0]) * LIMIT_W'(MS_PER_SEC);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target           <= RST_TARGET;
            r_cfg.approach_depth   <= RST_APPROACH;
            r_cfg.landing_depth    <= RST_LANDING;
            r_cfg.hysteresis       <= RST_HYST;
            r_cfg.stable_limit_ms  <= RST_STABLE_LIMIT;
            r_cfg.vacancy_limit_ms <= RST_VACANT_LIMIT;
            r_cfg.fast_period      <= RST_FAST;
            r_cfg.slow_period      <= RST_SLOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET:   r_cfg.target           <= i_cfg_data[DIST_W-1:0];
                CFG_APPROACH: r_cfg.approach_depth   <= i_cfg_data[DIST_W-1:0];
                CFG_LANDING:  r_cfg.landing_depth    <= i_cfg_data[DIST_W-1:0];
                CFG_HYST:     r_cfg.hysteresis       <= i_cfg_data[HYST_W-1:0];
                CFG_STABLE:   r_cfg.stable_limit_ms  <= w_limit_ms;
                CFG_VACANCY:  r_cfg.vacancy_limit_ms <= w_limit_ms;
                CFG_FAST:     r_cfg.fast_period      <= i_cfg_data[PERIOD_W-1:0];
                CFG_SLOW:     r_cfg.slow_period      <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/ppmc_step.sv */
// Next-state logic of the six-mode controller for one evaluation beat.
module ppmc_step (
    input  ppmc_pkg::t_cfg      i_cfg,
    input  ppmc_pkg::t_state    i_state,
    input  ppmc_pkg::t_in_item  i_item,
    output ppmc_pkg::t_state    o_state,
    output ppmc_pkg::t_out_item o_item
);
    import ppmc_pkg::*;

    logic signed [THR_W-1:0] w_avg;
    logic signed [THR_W-1:0] w_latest;
    logic signed [THR_W-1:0] w_target;
    logic signed [THR_W-1:0] w_hyst;
    logic signed [THR_W-1:0] w_approach;
    logic signed [THR_W-1:0] w_warn;
    logic [TIMER_BITS-1:0]   w_stable_sum;
    logic [TIMER_BITS-1:0]   w_vacancy_sum;
    t_state                  n_state;

    // Thresholds, all compared as signed so a negative warning level never matches.
    assign w_avg      = signed'(THR_W'(i_item.distance_avg));
    assign w_latest   = signed'(THR_W'(i_item.distance_latest));
    assign w_target   = signed'(THR_W'(i_cfg.target));
    assign w_hyst     = signed'(THR_W'(i_cfg.hysteresis));
    assign w_approach = w_target + signed'(THR_W'(i_cfg.approach_depth));
    assign w_warn     = w_target - signed'(THR_W'(i_cfg.landing_depth));

    assign w_stable_sum  = timer_add(i_state.stable_ms, i_item.elapsed_ms);
    assign w_vacancy_sum = timer_add(i_state.vacancy_ms, i_item.elapsed_ms);

    // Mode transitions; entering a mode also sets its sample period and timer.
    always_comb begin
        n_state = i_state;
        unique case (i_state.mode)
            MODE_VACANT: begin
                if (w_avg < w_approach) begin
                    n_state.mode = MODE_HOMING;
                end
                // A near car on the raw reading latches the fast period.
                if (w_avg < w_approach ||
                    w_latest < w_approach + signed'(THR_W'(MARGIN_TENTHS))) begin
                    n_state.period = i_cfg.fast_period;
                end
            end
            MODE_HOMING: begin
                if (w_avg > w_approach + w_hyst) begin
                    n_state.mode   = MODE_VACANT;
                    n_state.period = i_cfg.slow_period;
                end else if (w_avg <= w_target) begin
                    n_state.mode      = MODE_HOME;
                    n_state.period    = i_cfg.fast_period;
                    n_state.stable_ms = '0;
                end
            end
            MODE_HOME: begin
                n_state.stable_ms = w_stable_sum;
                if (w_avg > w_target + w_hyst) begin
                    n_state.mode   = MODE_HOMING;
                    n_state.period = i_cfg.fast_period;
                end else if (w_avg <= w_warn) begin
                    n_state.mode   = MODE_CLOSE;
                    n_state.period = i_cfg.fast_period;
                end else if (timer_expired(w_stable_sum, i_cfg.stable_limit_ms)) begin
                    n_state.mode       = MODE_PARKED;
                    n_state.period     = i_cfg.slow_period;
                    n_state.vacancy_ms = '0;
                end
            end
            MODE_CLOSE: begin
                if (w_avg > w_warn + w_hyst) begin
                    n_state.mode      = MODE_HOME;
                    n_state.period    = i_cfg.fast_period;
                    n_state.stable_ms = '0;
                end
            end
            MODE_PARKED: begin
                if (w_avg < w_approach) begin
                    n_state.vacancy_ms = '0;
                end else begin
                    n_state.vacancy_ms = w_vacancy_sum;
                    if (timer_expired(w_vacancy_sum, i_cfg.vacancy_limit_ms)) begin
                        n_state.mode   = MODE_VACANT;
                        n_state.period = i_cfg.slow_period;
                    end
                end
                // Losing daytime wins over a move to vacant.
                if (!i_item.daytime) begin
                    n_state.mode   = MODE_NIGHT;
                    n_state.period = '0;
                end
            end
            default: begin
                // Night, and any code outside the mode list.
                if (i_item.daytime) begin
                    n_state.mode   = MODE_VACANT;
                    n_state.period = i_cfg.slow_period;
                end else begin
                    n_state.mode   = MODE_NIGHT;
                    n_state.period = '0;
                end
            end
        endcase
    end

    assign o_state                 = n_state;
    assign o_item.mode             = n_state.mode;
    assign o_item.mode_changed     = (n_state.mode != i_state.mode);
    assign o_item.sample_period_ms = n_state.period;

endmodule

/* hdl/parking_proximity_mode_controller_top.sv */
// Top level of the parking proximity mode controller: beat registers, state and handshakes.
// Each accepted input beat is one evaluation tick. It is captured in an input register,
// evaluated against the mode state in a single pass, and its result is registered in an
// output register once that register is free. One beat per cycle is sustained while the
// consumer does not stall: the mode and timer registers are updated with each evaluated
// beat, so back-to-back beats see each other's state. The input side stalls only while a
// beat is waiting in the input register and the output register is held by a stalled
// consumer. Configuration writes are always ready and take effect on the next cycle; the
// two timeouts are converted from seconds to milliseconds on write.
module parking_proximity_mode_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ppmc_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ppmc_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppmc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ppmc_pkg::*;

    t_cfg      w_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      w_out_blocked;
    logic      w_advance;
    logic      w_accept;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    ppmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Mode evaluation
    ppmc_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_item  (n_out)
    );

    // Flow control between the two beat registers
    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_advance     = r_in_valid && !w_out_blocked;
    assign o_in_stall    = r_in_valid && w_out_blocked;
    assign w_accept      = i_in_valid && !o_in_stall;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state.mode       <= MODE_NIGHT;
            r_state.stable_ms  <= '0;
            r_state.vacancy_ms <= '0;
            r_state.period     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Beat payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Night mode never samples.
    a_night_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_NIGHT) |-> (r_state.period == '0))
        else $error("night mode with a running sample period");

    // The input side stalls only when a beat is held behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // An evaluated beat always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("evaluated beat produced no result");

    // A fresh result reports the mode now held in the state register.
    a_mode_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_advance) |-> (o_out_data.mode == r_state.mode))
        else $error("result mode differs from state mode");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the parking proximity mode controller.
module testbench;
    import ppmc_pkg::*;

    // One step of the directed plan: either a register write or a tick with its known result.
    typedef struct {
        bit                 is_write;
        t_cfg_idx           reg_idx;
        logic [CFG_W-1:0]   reg_val;
        t_in_item           tick;
        t_out_item          want;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    parking_proximity_mode_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the registers, starting at their reset values.
    logic [DIST_W-1:0]   cfg_target      = DIST_W'(450);
    logic [DIST_W-1:0]   cfg_approach    = DIST_W'(480);
    logic [DIST_W-1:0]   cfg_landing     = DIST_W'(50);
    logic [HYST_W-1:0]   cfg_hyst        = HYST_W'(15);
    logic [SEC_W-1:0]    cfg_stable_sec  = SEC_W'(600);
    logic [SEC_W-1:0]    cfg_vacancy_sec = SEC_W'(60);
    logic [PERIOD_W-1:0] cfg_fast        = PERIOD_W'(200);
    logic [PERIOD_W-1:0] cfg_slow        = PERIOD_W'(1500);

    // Shadow copy of the mode state.
    t_mode                 pm_mode       = MODE_NIGHT;
    logic [TIMER_BITS-1:0] pm_stable_ms  = '0;
    logic [TIMER_BITS-1:0] pm_vacancy_ms = '0;
    logic [PERIOD_W-1:0]   pm_period     = '0;

    t_out_item tick_results_q[$];
    t_plan_row directed_plan[$];
    int        fail_count = 0;
    int        tx_burst   = 0;
    int        rx_burst   = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // Millisecond timer add that stops at all ones.
    function automatic logic [TIMER_BITS-1:0] timer_sum(input logic [TIMER_BITS-1:0] t,
                                                         input logic [ELAPSED_W-1:0] inc);
        longint s;
        longint cap;
        cap = (longint'(1) << TIMER_BITS) - 1;
        s = longint'(t) + longint'(inc);
        if (s > cap) s = cap;
        return s[TIMER_BITS-1:0];
    endfunction

    // Mode entry: the period and timer side effects of each mode.
    function automatic void enter_mode(input t_mode m);
        pm_mode = m;
        case (m)
            MODE_NIGHT: pm_period = '0;
            MODE_VACANT, MODE_PARKED: pm_period = cfg_slow;
            default: pm_period = cfg_fast;
        endcase
        if (m == MODE_HOME) pm_stable_ms = '0;
        if (m == MODE_PARKED) pm_vacancy_ms = '0;
    endfunction

    // Advances the shadow state by one tick and returns the result it should produce.
    function automatic t_out_item evaluate_tick(input t_in_item it);
        int        avg;
        int        latest;
        int        tgt;
        int        hyst;
        int        appr;
        int        warn;
        t_mode     start;
        t_out_item r;
        avg    = int'(it.distance_avg);
        latest = int'(it.distance_latest);
        tgt    = int'(cfg_target);
        hyst   = int'(cfg_hyst);
        appr   = tgt + int'(cfg_approach);
        warn   = tgt - int'(cfg_landing);
        start  = pm_mode;
        case (start)
            MODE_VACANT: begin
                if (avg < appr) enter_mode(MODE_HOMING);
                // A near raw reading latches the fast period while still vacant.
                if (latest < appr + MARGIN_TENTHS) pm_period = cfg_fast;
            end
            MODE_HOMING: begin
                if (avg > appr + hyst) enter_mode(MODE_VACANT);
                else if (avg <= tgt) enter_mode(MODE_HOME);
            end
            MODE_HOME: begin
                pm_stable_ms = timer_sum(pm_stable_ms, it.elapsed_ms);
                if (avg > tgt + hyst) enter_mode(MODE_HOMING);
                else if (avg <= warn) enter_mode(MODE_CLOSE);
                else if (longint'(pm_stable_ms) > longint'(cfg_stable_sec) * MS_PER_SEC)
                    enter_mode(MODE_PARKED);
            end
            MODE_CLOSE: begin
                if (avg > warn + hyst) enter_mode(MODE_HOME);
            end
            MODE_PARKED: begin
                if (avg < appr) begin
                    pm_vacancy_ms = '0;
                end else begin
                    pm_vacancy_ms = timer_sum(pm_vacancy_ms, it.elapsed_ms);
                    if (longint'(pm_vacancy_ms) > longint'(cfg_vacancy_sec) * MS_PER_SEC)
                        enter_mode(MODE_VACANT);
                end
                // Losing daylight wins over a vacancy move on the same tick.
                if (!it.daytime) enter_mode(MODE_NIGHT);
            end
            default: begin
                if (it.daytime) enter_mode(MODE_VACANT);
                else enter_mode(MODE_NIGHT);
            end
        endcase
        r.mode             = pm_mode;
        r.mode_changed     = (pm_mode != start);
        r.sample_period_ms = pm_period;
        return r;
    endfunction

    // Updates the shadow registers, keeping only the bits each register holds.
    function automatic void apply_write(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        case (idx)
            CFG_TARGET:   cfg_target      = v[DIST_W-1:0];
            CFG_APPROACH: cfg_approach    = v[DIST_W-1:0];
            CFG_LANDING:  cfg_landing     = v[DIST_W-1:0];
            CFG_HYST:     cfg_hyst        = v[HYST_W-1:0];
            CFG_STABLE:   cfg_stable_sec  = v;
            CFG_VACANCY:  cfg_vacancy_sec = v;
            CFG_FAST:     cfg_fast        = v;
            default:      cfg_slow        = v;
        endcase
    endfunction

    function automatic t_plan_row tick_row(input int avg, input int latest, input bit day,
                                           input int el, input t_mode m, input bit chg,
                                           input int per);
        t_plan_row r;
        r.is_write                = 1'b0;
        r.reg_idx                 = CFG_TARGET;
        r.reg_val                 = '0;
        r.tick.distance_avg       = DIST_W'(avg);
        r.tick.distance_latest    = DIST_W'(latest);
        r.tick.daytime            = day;
        r.tick.elapsed_ms         = ELAPSED_W'(el);
        r.want.mode               = m;
        r.want.mode_changed       = chg;
        r.want.sample_period_ms   = PERIOD_W'(per);
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input t_cfg_idx idx, input int val);
        t_plan_row r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = CFG_W'(val);
        r.tick     = '0;
        r.want     = '0;
        return r;
    endfunction

    function automatic int near(input int x);
        int v;
        v = x + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // Random tick whose averaged distance mostly sits on the thresholds of the current mode.
    function automatic t_in_item random_tick();
        t_in_item it;
        int       tgt;
        int       hyst;
        int       appr;
        int       warn;
        int       lo;
        int       hi;
        int       avg;
        int       r;
        tgt  = int'(cfg_target);
        hyst = int'(cfg_hyst);
        appr = tgt + int'(cfg_approach);
        warn = tgt - int'(cfg_landing);
        r    = $urandom_range(0, 7);
        if (r == 0) begin
            avg = $urandom_range(0, 4095);
        end else if (r == 1) begin
            avg = $urandom_range(0, 1) ? 4095 : 0;
        end else begin
            case (pm_mode)
                MODE_VACANT: avg = near(appr);
                MODE_HOMING: avg = $urandom_range(0, 1) ? near(appr + hyst) : near(tgt);
                MODE_HOME: begin
                    case ($urandom_range(0, 3))
                        0: avg = near(tgt + hyst);
                        1: avg = near(warn);
                        default: begin
                            // Stay inside the home band so the stable timer can run out.
                            lo = (warn + 1 < 0) ? 0 : warn + 1;
                            hi = (tgt + hyst > 4095) ? 4095 : tgt + hyst;
                            avg = (lo <= hi) ? int'($urandom_range(lo, hi)) : near(tgt);
                        end
                    endcase
                end
                MODE_CLOSE: avg = near(warn + hyst);
                MODE_PARKED: begin
                    if ($urandom_range(0, 4) < 3 && appr <= 4095)
                        avg = $urandom_range(appr, 4095);
                    else
                        avg = near(appr);
                end
                default: avg = $urandom_range(0, 4095);
            endcase
        end
        it.distance_avg    = DIST_W'(avg);
        it.distance_latest = $urandom_range(0, 1) ? DIST_W'(near(appr + MARGIN_TENTHS))
                                                  : DIST_W'($urandom_range(0, 4095));
        it.daytime         = ($urandom_range(0, 15) != 0);
        case ($urandom_range(0, 7))
            0: it.elapsed_ms = '0;
            1: it.elapsed_ms = '1;
            default: it.elapsed_ms = ELAPSED_W'($urandom_range(0, 1023));
        endcase
        return it;
    endfunction

    // Idle length: mostly none or short, a few long, with occasional runs of no idling.
    task automatic idle_span(inout int burst, output int span);
        int r;
        r = $urandom_range(0, 99);
        if (burst > 0) begin
            burst--;
            span = 0;
        end else if (r < 3) begin
            burst = $urandom_range(10, 40);
            span = 0;
        end else if (r < 50) begin
            span = 0;
        end else if (r < 85) begin
            span = $urandom_range(1, 3);
        end else if (r < 97) begin
            span = $urandom_range(4, 10);
        end else begin
            span = $urandom_range(20, 40);
        end
    endtask

    // Offers one tick beat and records the result it should cause once it is taken.
    task automatic send_tick(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        idle_span(tx_burst, gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = evaluate_tick(it);
        tick_results_q.push_back(typed ? want : predicted);
    endtask

    // Holds off new ticks until every outstanding result has been returned.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tick_results_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_write(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes every register: all zeros, all ones, or a random setting with small timeouts.
    task automatic load_setting(input int kind);
        logic [CFG_W-1:0] v;
        logic [CFG_W-1:0] spare;
        for (int i = int'(CFG_TARGET); i <= int'(CFG_SLOW); i++) begin
            spare = '0;
            case (t_cfg_idx'(i))
                CFG_TARGET: begin
                    if ($urandom_range(0, 4) == 0)
                        v = $urandom_range(0, 1) ? CFG_W'(4095) : CFG_W'(0);
                    else v = CFG_W'($urandom_range(0, 4095));
                    spare = 16'hF000;
                end
                CFG_APPROACH: begin
                    v = CFG_W'($urandom_range(0, 1500));
                    spare = 16'hF000;
                end
                CFG_LANDING: begin
                    v = CFG_W'($urandom_range(0, 700));
                    spare = 16'hF000;
                end
                CFG_HYST: begin
                    v = ($urandom_range(0, 7) == 0) ? CFG_W'(1023)
                                                    : CFG_W'($urandom_range(0, 60));
                    spare = 16'hFC00;
                end
                CFG_STABLE, CFG_VACANCY: begin
                    v = ($urandom_range(0, 9) == 0) ? 16'hFFFF : CFG_W'($urandom_range(0, 3));
                end
                default: v = CFG_W'($urandom_range(0, 65535));
            endcase
            if (kind == 0) v = '0;
            else if (kind == 1) v = '1;
            else if ($urandom_range(0, 3) == 0) v = v | (CFG_W'($urandom) & spare);
            write_reg(t_cfg_idx'(i), v);
        end
    endtask

    // Compares a returned result beat with the oldest one still expected.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (tick_results_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result beat: mode %0d changed %0d period %0d",
                         got.mode, got.mode_changed, got.sample_period_ms);
            return;
        end
        want = tick_results_q.pop_front();
        if (got.mode !== want.mode || got.mode_changed !== want.mode_changed ||
            got.sample_period_ms !== want.sample_period_ms) begin
            fail_count++;
            if (fail_count <= 10)
                $display({"result mismatch: expected mode %0d changed %0d period %0d, ",
                          "got %0d %0d %0d"},
                         want.mode, want.mode_changed, want.sample_period_ms,
                         got.mode, got.mode_changed, got.sample_period_ms);
        end
    endtask

    // Result side: random stalls, checking every beat that is taken.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) check_result(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                idle_span(rx_burst, hold_left);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus: reset, the directed walk through every mode, then random phases.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: approach 930, warning 400, hysteresis 15.
        directed_plan.push_back(tick_row(0, 0, 0, 0, MODE_NIGHT, 0, 0));
        directed_plan.push_back(tick_row(4095, 4095, 1, 1023, MODE_VACANT, 1, 1500));
        directed_plan.push_back(tick_row(4095, 0, 1, 0, MODE_VACANT, 0, 200));
        directed_plan.push_back(tick_row(0, 4095, 1, 0, MODE_HOMING, 1, 200));
        directed_plan.push_back(tick_row(946, 0, 1, 0, MODE_VACANT, 1, 1500));
        directed_plan.push_back(tick_row(929, 4095, 1, 0, MODE_HOMING, 1, 200));
        directed_plan.push_back(tick_row(450, 0, 1, 0, MODE_HOME, 1, 200));
        directed_plan.push_back(tick_row(465, 0, 1, 1023, MODE_HOME, 0, 200));
        directed_plan.push_back(tick_row(466, 0, 1, 0, MODE_HOMING, 1, 200));
        directed_plan.push_back(tick_row(0, 0, 1, 0, MODE_HOME, 1, 200));
        directed_plan.push_back(tick_row(400, 0, 1, 0, MODE_CLOSE, 1, 200));
        directed_plan.push_back(tick_row(415, 0, 1, 0, MODE_CLOSE, 0, 200));
        directed_plan.push_back(tick_row(416, 0, 1, 0, MODE_HOME, 1, 200));
        // Zero timeouts: any elapsed time parks, then vacates.
        directed_plan.push_back(cfg_row(CFG_STABLE, 0));
        directed_plan.push_back(cfg_row(CFG_VACANCY, 0));
        directed_plan.push_back(tick_row(450, 0, 1, 0, MODE_HOME, 0, 200));
        directed_plan.push_back(tick_row(450, 0, 1, 1, MODE_PARKED, 1, 1500));
        directed_plan.push_back(tick_row(0, 4095, 1, 1023, MODE_PARKED, 0, 1500));
        directed_plan.push_back(tick_row(4095, 0, 1, 1, MODE_VACANT, 1, 1500));
        directed_plan.push_back(tick_row(0, 4095, 1, 0, MODE_HOMING, 1, 200));
        directed_plan.push_back(tick_row(0, 0, 1, 0, MODE_HOME, 1, 200));
        directed_plan.push_back(tick_row(450, 0, 1, 1, MODE_PARKED, 1, 1500));
        // Night overrides a vacancy move on the same tick.
        directed_plan.push_back(tick_row(4095, 0, 0, 5, MODE_NIGHT, 1, 0));
        directed_plan.push_back(tick_row(0, 0, 0, 0, MODE_NIGHT, 0, 0));
        // A landing depth beyond the target makes the warning negative: no too close.
        directed_plan.push_back(cfg_row(CFG_LANDING, 4095));
        directed_plan.push_back(tick_row(0, 4095, 1, 0, MODE_VACANT, 1, 1500));
        directed_plan.push_back(tick_row(0, 4095, 1, 0, MODE_HOMING, 1, 200));
        directed_plan.push_back(tick_row(0, 0, 1, 0, MODE_HOME, 1, 200));
        directed_plan.push_back(tick_row(0, 0, 1, 0, MODE_HOME, 0, 200));

        foreach (directed_plan[n]) begin
            if (directed_plan[n].is_write) begin
                drain_results();
                write_reg(directed_plan[n].reg_idx, directed_plan[n].reg_val);
            end else begin
                send_tick(directed_plan[n].tick, 1'b1, directed_plan[n].want);
            end
        end

        // Random phases, each under a fresh register setting.
        for (int phase = 0; phase < 9; phase++) begin
            drain_results();
            load_setting(phase);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 99) == 0) drain_results();
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && tick_results_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
